FILE: rtl/olie_pkg.sv
// olie_pkg: request/result item types, op and status codes, cell control bundle
// for the ordered list insert engine. No dependencies.
package olie_pkg;

    localparam int CNT_W = 6;
    localparam int DAT_W = 32;

    localparam logic [2:0] OP_FRONT  = 3'd0;
    localparam logic [2:0] OP_BACK   = 3'd1;
    localparam logic [2:0] OP_BEFORE = 3'd2;
    localparam logic [2:0] OP_AFTER  = 3'd3;
    localparam logic [2:0] OP_DUMP   = 3'd4;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_COUNT     = 3'd3;
    localparam logic [2:0] ST_ENTRY     = 3'd4;

    typedef struct packed {
        logic [2:0]        op;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic signed [31:0] entry;
        logic [5:0]        count;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic       load_match;
        logic       apply;
        logic       rotate;
        logic [2:0] op;
    } cell_ctrl_t;

endpackage

FILE: rtl/olie_cell.sv
// olie_cell: one list slot of the cell chain; key match, insert shift, dump rotate.
// Depends on olie_pkg.
module olie_cell #(
    parameter int IDX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  olie_pkg::cell_ctrl_t        ctrl,
    input  logic [olie_pkg::DAT_W-1:0]  key,
    input  logic [olie_pkg::DAT_W-1:0]  value,
    input  logic [olie_pkg::CNT_W-1:0]  len,
    input  logic [olie_pkg::DAT_W-1:0]  left_data,
    input  logic [olie_pkg::DAT_W-1:0]  right_data,
    input  logic [olie_pkg::DAT_W-1:0]  head_data,
    input  logic                        seen_in,
    input  logic                        first_in,
    output logic                        seen_out,
    output logic                        first_out,
    output logic [olie_pkg::DAT_W-1:0]  data
);
    import olie_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

    logic [DAT_W-1:0] data_reg;
    logic [DAT_W-1:0] data_next;
    logic             match_reg;
    logic             match_next;
    logic             at_pos;
    logic             shift;

    assign seen_out  = seen_in | match_reg;
    assign first_out = match_reg & ~seen_in;
    assign data      = data_reg;

    assign match_next = ctrl.load_match ? ((data_reg == key) && (MY_IDX < len)) : match_reg;

    always_comb
    begin
        at_pos = 1'b0;
        shift  = 1'b0;
        unique case (ctrl.op)
            OP_FRONT:
            begin
                at_pos = (IDX == 0);
                shift  = (IDX != 0);
            end
            OP_BACK:
            begin
                at_pos = (MY_IDX == len);
            end
            OP_BEFORE:
            begin
                at_pos = match_reg & ~seen_in;
                shift  = seen_in;
            end
            OP_AFTER:
            begin
                at_pos = first_in;
                shift  = seen_in & ~first_in;
            end
            default:
            begin
                at_pos = 1'b0;
                shift  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.apply)
        begin
            if (at_pos)
                data_next = value;
            else if (shift)
                data_next = left_data;
        end
        else if (ctrl.rotate)
        begin
            data_next = (MY_NEXT == len) ? head_data : right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= 1'b0;
        else
            match_reg <= match_next;
    end

endmodule

FILE: rtl/ordered_list_insert_engine.sv
// ordered_list_insert_engine: top level; request sequencer, length, result register
// and the chain of olie_cell slots. Depends on olie_pkg and olie_cell.
//
//  channel | signals                      | payload
//  --------+------------------------------+----------------------------
//  req     | req_valid, req_ready, req    | in_item_t  (op, key, value)
//  res     | res_valid, res_ready, res    | out_item_t (status, entry, count, last)
//
// Insert: the accept cycle registers the per-cell key match; S_EXEC shifts the cells.
// Dump: after the accept cycle come 1 + length results, one per cycle unless stalled,
// read from cell 0 while the occupied cells rotate once around. Unused ops finish
// in the accept cycle. Reset clears length and control; cell contents are not reset.
// A stalled result holds its register; the sequencer waits while it is not taken.
module ordered_list_insert_engine #(
    parameter int CAPACITY = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  olie_pkg::in_item_t   req,
    output logic                 res_valid,
    input  logic                 res_ready,
    output olie_pkg::out_item_t  res
);
    import olie_pkg::*;

    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_EXEC     = 2'd1;
    localparam logic [1:0] S_DUMP_CNT = 2'd2;
    localparam logic [1:0] S_DUMP_ENT = 2'd3;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [1:0]       state_reg, state_next;
    logic [2:0]       op_reg, op_next;
    logic [DAT_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             res_valid_reg, res_valid_next;
    out_item_t        res_reg, res_next;

    logic             accept;
    logic             res_free;
    logic             found;
    logic [2:0]       exec_status;
    cell_ctrl_t       ctrl;

    logic [DAT_W-1:0] cell_data [CAPACITY];
    logic             seen  [CAPACITY+1];
    logic             first [CAPACITY+1];

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid & req_ready;
    assign res_free  = ~res_valid_reg | res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign seen[0]  = 1'b0;
    assign first[0] = 1'b0;
    assign found    = seen[CAPACITY];

    always_comb
    begin
        if (len_reg == CAP_CNT)
            exec_status = ST_FULL;
        else if ((op_reg == OP_BEFORE || op_reg == OP_AFTER) && !found)
            exec_status = ST_NOT_FOUND;
        else
            exec_status = ST_INSERTED;
    end

    always_comb
    begin
        ctrl.load_match = accept;
        ctrl.apply      = (state_reg == S_EXEC) && res_free && (exec_status == ST_INSERTED);
        ctrl.rotate     = (state_reg == S_DUMP_ENT) && res_free;
        ctrl.op         = op_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        value_next     = value_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        res_valid_next = res_valid_reg & ~res_ready;
        res_next       = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = req.op;
                    value_next = req.value;
                    if (req.op == OP_DUMP)
                        state_next = S_DUMP_CNT;
                    else if (req.op < OP_DUMP)
                        state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (res_free)
                begin
                    if (exec_status == ST_INSERTED)
                        len_next = len_reg + 1'b1;
                    res_valid_next = 1'b1;
                    res_next.status = exec_status;
                    res_next.entry  = '0;
                    res_next.count  = (exec_status == ST_INSERTED) ? len_reg + 1'b1 : len_reg;
                    res_next.last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_DUMP_CNT:
            begin
                if (res_free)
                begin
                    res_valid_next  = 1'b1;
                    res_next.status = ST_COUNT;
                    res_next.entry  = '0;
                    res_next.count  = len_reg;
                    res_next.last   = (len_reg == '0);
                    idx_next        = '0;
                    state_next      = (len_reg == '0) ? S_IDLE : S_DUMP_ENT;
                end
            end
            S_DUMP_ENT:
            begin
                if (res_free)
                begin
                    res_valid_next  = 1'b1;
                    res_next.status = ST_ENTRY;
                    res_next.entry  = cell_data[0];
                    res_next.count  = len_reg;
                    res_next.last   = (idx_reg + 1'b1 == len_reg);
                    idx_next        = idx_reg + 1'b1;
                    if (idx_reg + 1'b1 == len_reg)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
            op_reg        <= OP_FRONT;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
            op_reg        <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        res_reg   <= res_next;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [DAT_W-1:0] left_d;
            logic [DAT_W-1:0] right_d;
            if (g == 0)
            begin : g_lft0
                assign left_d = cell_data[g];
            end
            else
            begin : g_lft
                assign left_d = cell_data[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_rgt0
                assign right_d = cell_data[g];
            end
            else
            begin : g_rgt
                assign right_d = cell_data[g+1];
            end
            olie_cell #(
                .IDX (g)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .key        (req.key),
                .value      (value_reg),
                .len        (len_reg),
                .left_data  (left_d),
                .right_data (right_d),
                .head_data  (cell_data[0]),
                .seen_in    (seen[g]),
                .first_in   (first[g]),
                .seen_out   (seen[g+1]),
                .first_out  (first[g+1]),
                .data       (cell_data[g])
            );
        end
    endgenerate

endmodule
